@@ hdl/dsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared types and constants of the DER signature parser.
// ----------------------------------------------------------------------------
package dsp_pkg;

	typedef enum logic [3:0] {
		PH_SEQ_TAG = 4'd0,
		PH_SEQ_LEN = 4'd1,
		PH_R_TAG   = 4'd2,
		PH_R_LEN   = 4'd3,
		PH_R_VAL   = 4'd4,
		PH_S_TAG   = 4'd5,
		PH_S_LEN   = 4'd6,
		PH_S_VAL   = 4'd7,
		PH_DONE    = 4'd8
	} dsp_phase_t;

	localparam logic [7:0] TAG_SEQUENCE = 8'h30;
	localparam logic [7:0] TAG_INTEGER  = 8'h02;
	localparam logic [7:0] LEAD_ZERO    = 8'h00;

	localparam int         COUNT_W   = 9;
	localparam logic [8:0] COUNT_MAX = 9'd511;
	localparam logic [8:0] MIN_BYTES = 9'd6;

	// end-of-signature verdict handed from parser to output buffer
	typedef struct packed {
		logic fire;
		logic ok;
	} dsp_result_t;

endpackage
`default_nettype wire

@@ hdl/dsp_byte_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsp_byte_if
// Byte channel carrying the DER encoding, one byte per item.
// ----------------------------------------------------------------------------
interface dsp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

@@ hdl/dsp_word_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsp_word_if
// Result channel carrying raw r and s as 64-bit big-endian words.
// ----------------------------------------------------------------------------
interface dsp_word_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_word;
	logic        ok;
	logic        out_last;

	modport source (output valid, output out_word, output ok, output out_last,
		input ready);
	modport sink   (input valid, input out_word, input ok, input out_last,
		output ready);
endinterface
`default_nettype wire

@@ hdl/der_signature_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// der_signature_parser
// DER SEQUENCE { INTEGER r, INTEGER s } to raw r || s converter.
// ----------------------------------------------------------------------------
// Takes the encoding one byte per item and one item per clock. Every byte is
// checked and the value bytes are shifted into a register line as they come,
// so the parse keeps pace with the stream. On the final byte the verdict
// loads an output buffer, which sends (2*COORD_BYTES+7)/8 words marked ok, or
// one all-zero item with ok low, at one word per cycle while ready is high.
// Non-final bytes of the next signature are taken while the buffer drains;
// a final byte waits only while the previous signature's words are unsent.
// ----------------------------------------------------------------------------
module der_signature_parser
	import dsp_pkg::*;
#(
	parameter int COORD_BYTES = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dsp_byte_if.sink   der,
	dsp_word_if.source raw
);

	localparam int RAW_BYTES = 2 * COORD_BYTES;

	dsp_result_t res;
	logic [7:0]  store_nx [RAW_BYTES];
	logic        free;
	logic        accept;

	assign der.ready = free || !der.in_last;
	assign accept    = der.valid && der.ready;

	dsp_parser #(.COORD_BYTES(COORD_BYTES)) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (der.in_byte),
		.in_last  (der.in_last),
		.res      (res),
		.store_nx (store_nx)
	);

	dsp_drain #(.COORD_BYTES(COORD_BYTES)) u_drain (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.store  (store_nx),
		.free   (free),
		.raw    (raw)
	);

	// a rejected signature is one zero item
	a_fail_single: assert property (@(posedge clk) disable iff (!arst_n)
		raw.valid && !raw.ok |-> raw.out_last && raw.out_word == 64'd0)
		else $error("fail item not single or not zero");

	// a verdict is never taken while words of the previous one are unsent
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res.fire |-> free)
		else $error("output buffer overrun");

	// a verdict shows up on the result side in the next cycle
	a_verdict_out: assert property (@(posedge clk) disable iff (!arst_n)
		res.fire |=> raw.valid && raw.ok == $past(res.ok))
		else $error("verdict not presented");

endmodule
`default_nettype wire

@@ hdl/dsp_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsp_parser
// Per-byte DER checks, byte counter and the shift line of value bytes.
// ----------------------------------------------------------------------------
module dsp_parser
	import dsp_pkg::*;
#(
	parameter int COORD_BYTES = 32,
	localparam int RAW_BYTES = 2 * COORD_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [7:0]  in_byte,
	input  wire logic        in_last,
	output dsp_result_t      res,
	output logic [7:0]       store_nx [RAW_BYTES]
);

	localparam int         LEFT_W     = $clog2(COORD_BYTES + 2);
	localparam logic [7:0] LEN_SHORT  = 8'(COORD_BYTES);
	localparam logic [7:0] LEN_LONG   = 8'(COORD_BYTES + 1);
	localparam logic [LEFT_W-1:0] LEFT_LONG = LEFT_W'(COORD_BYTES + 1);
	localparam logic [LEFT_W-1:0] LEFT_ONE  = LEFT_W'(1);

	dsp_phase_t         phase_q, phase_n;
	logic [COUNT_W-1:0] count_q, count_n;
	logic [7:0]         len_q, len_n;
	logic [LEFT_W-1:0]  left_q, left_n;
	logic               fail_q, fail_n;
	logic               shift;
	logic [7:0]         store_q [RAW_BYTES];

	always_comb begin
		phase_n = phase_q;
		len_n   = len_q;
		left_n  = left_q;
		fail_n  = fail_q;
		shift   = 1'b0;
		count_n = (count_q == COUNT_MAX) ? count_q : count_q + 9'd1;
		if (!fail_q) begin
			case (phase_q)
				PH_SEQ_TAG: begin
					if (in_byte != TAG_SEQUENCE) fail_n = 1'b1;
					else phase_n = PH_SEQ_LEN;
				end
				PH_SEQ_LEN: begin
					len_n   = in_byte;
					phase_n = PH_R_TAG;
				end
				PH_R_TAG, PH_S_TAG: begin
					if (in_byte != TAG_INTEGER) fail_n = 1'b1;
					else phase_n = (phase_q == PH_R_TAG) ? PH_R_LEN : PH_S_LEN;
				end
				PH_R_LEN, PH_S_LEN: begin
					if (in_byte == LEN_SHORT || in_byte == LEN_LONG) begin
						left_n  = in_byte[LEFT_W-1:0];
						phase_n = (phase_q == PH_R_LEN) ? PH_R_VAL : PH_S_VAL;
					end else begin
						fail_n = 1'b1;
					end
				end
				PH_R_VAL, PH_S_VAL: begin
					// the extra leading byte of a long value must be zero and is dropped
					if (left_q == LEFT_LONG) begin
						if (in_byte != LEAD_ZERO) fail_n = 1'b1;
					end else begin
						shift = accept;
					end
					left_n = left_q - LEFT_ONE;
					if (left_q == LEFT_ONE)
						phase_n = (phase_q == PH_R_VAL) ? PH_S_TAG : PH_DONE;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		res.fire = accept && in_last;
		res.ok   = !fail_n && phase_n == PH_DONE && count_n >= MIN_BYTES
			&& count_n == {1'b0, len_n} + 9'd2;
	end

	// value bytes enter at the top, so the first r byte ends at index zero
	always_comb begin
		for (int i = 0; i < RAW_BYTES - 1; i++)
			store_nx[i] = shift ? store_q[i+1] : store_q[i];
		store_nx[RAW_BYTES-1] = shift ? in_byte : store_q[RAW_BYTES-1];
	end

	always_ff @(posedge clk) begin
		store_q <= store_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEQ_TAG;
			count_q <= '0;
			len_q   <= '0;
			left_q  <= '0;
			fail_q  <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				phase_q <= PH_SEQ_TAG;
				count_q <= '0;
				len_q   <= '0;
				left_q  <= '0;
				fail_q  <= 1'b0;
			end else begin
				phase_q <= phase_n;
				count_q <= count_n;
				len_q   <= len_n;
				left_q  <= left_n;
				fail_q  <= fail_n;
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/dsp_drain.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsp_drain
// Output buffer: captures the raw bytes of a finished signature and sends
// them as big-endian words, or sends a single fail item.
// ----------------------------------------------------------------------------
module dsp_drain
	import dsp_pkg::*;
#(
	parameter int COORD_BYTES = 32,
	localparam int RAW_BYTES = 2 * COORD_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dsp_result_t res,
	input  wire logic [7:0]  store [RAW_BYTES],
	output logic             free,
	dsp_word_if.source       raw
);

	localparam int RAW_WORDS = (RAW_BYTES + 7) / 8;
	localparam int CNT_W     = $clog2(RAW_WORDS + 1);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RAW_WORDS);

	logic [63:0]      word_q [RAW_WORDS];
	logic [63:0]      load_word [RAW_WORDS];
	logic [CNT_W-1:0] cnt_q;
	logic             ok_q;
	logic             send;

	// pack bytes big-endian, zero past the end and on a fail
	always_comb begin
		for (int k = 0; k < RAW_WORDS; k++) begin
			for (int j = 0; j < 8; j++) begin
				if (res.ok && (k * 8 + j) < RAW_BYTES)
					load_word[k][63 - 8*j -: 8] = store[(k * 8 + j) % RAW_BYTES];
				else
					load_word[k][63 - 8*j -: 8] = 8'h00;
			end
		end
	end

	assign send = raw.valid && raw.ready;
	assign free = (cnt_q == '0) || (cnt_q == CNT_ONE && raw.ready);

	assign raw.valid    = (cnt_q != '0);
	assign raw.out_word = word_q[0];
	assign raw.ok       = ok_q;
	assign raw.out_last = (cnt_q == CNT_ONE);

	always_ff @(posedge clk) begin
		if (res.fire) begin
			word_q <= load_word;
		end else if (send) begin
			for (int k = 0; k < RAW_WORDS - 1; k++)
				word_q[k] <= word_q[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ok_q  <= 1'b0;
		end else if (res.fire) begin
			cnt_q <= res.ok ? CNT_FULL : CNT_ONE;
			ok_q  <= res.ok;
		end else if (send) begin
			cnt_q <= cnt_q - CNT_ONE;
		end
	end

endmodule
`default_nettype wire
